// ----- hdl/sprite_blit_clip_colorkey_core_assert.svh -----
// ----------------------------------------------------------------------------
// Sprite blit assertion macros
// Clocked, reset-gated property wrappers used by the sprite blit clip stage.
// ----------------------------------------------------------------------------
`ifndef SPRITE_BLIT_CLIP_COLORKEY_CORE_ASSERT_SVH
`define SPRITE_BLIT_CLIP_COLORKEY_CORE_ASSERT_SVH

// same-cycle implication
`define SBCK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBCK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sbck_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite blit package
// Shared constants, register indexes and stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sbck_pkg;

	localparam logic [8:0]  MAX_SPRITE_SIDE = 9'd256;
	localparam logic [12:0] MAX_SCREEN_SIDE = 13'd4096;

	typedef enum logic [2:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_SPRITE_COLS = 3'd2,
		REG_SPRITE_ROWS = 3'd3,
		REG_SCREEN_COLS = 3'd4,
		REG_SCREEN_ROWS = 3'd5,
		REG_KEY_ENABLE  = 3'd6,
		REG_KEY_COLOR   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [8:0]  sprite_cols;
		logic [8:0]  sprite_rows;
		logic [12:0] screen_cols;
		logic [12:0] screen_rows;
		logic        key_enable;
		logic [15:0] key_color;
	} cfg_t;

	typedef struct packed {
		logic [15:0] color;
		logic [7:0]  col;
		logic [7:0]  row;
		logic        rejected;
		logic        end_of_sprite;
	} scan_t;

endpackage

`default_nettype wire

// ----- hdl/sbck_cfg.sv -----
// ----------------------------------------------------------------------------
// Sprite blit configuration registers
// Holds origin, sprite size, screen size and key settings.
// ----------------------------------------------------------------------------
`default_nettype none

module sbck_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	output sbck_pkg::cfg_t     cfg
);

	sbck_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= 16'd0;
			cfg_q.origin_y    <= 16'd0;
			cfg_q.sprite_cols <= 9'd1;
			cfg_q.sprite_rows <= 9'd1;
			cfg_q.screen_cols <= 13'd0;
			cfg_q.screen_rows <= 13'd0;
			cfg_q.key_enable  <= 1'b0;
			cfg_q.key_color   <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				sbck_pkg::REG_ORIGIN_X:    cfg_q.origin_x    <= cfg_data;
				sbck_pkg::REG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_data;
				sbck_pkg::REG_SPRITE_COLS: cfg_q.sprite_cols <= cfg_data[8:0];
				sbck_pkg::REG_SPRITE_ROWS: cfg_q.sprite_rows <= cfg_data[8:0];
				sbck_pkg::REG_SCREEN_COLS: cfg_q.screen_cols <= cfg_data[12:0];
				sbck_pkg::REG_SCREEN_ROWS: cfg_q.screen_rows <= cfg_data[12:0];
				sbck_pkg::REG_KEY_ENABLE:  cfg_q.key_enable  <= cfg_data[0];
				sbck_pkg::REG_KEY_COLOR:   cfg_q.key_color   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/sbck_scan.sv -----
// ----------------------------------------------------------------------------
// Sprite blit scan stage
// Accepts pixels, walks the column and row counters, registers stage one.
// ----------------------------------------------------------------------------
`default_nettype none

module sbck_scan (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sbck_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [15:0]   src_color,
	input  wire logic          s2_ready,
	output logic               valid_s1,
	output sbck_pkg::scan_t    scan_s1
);

	logic [7:0]  col_q;
	logic [7:0]  row_q;
	logic        accept;
	logic        bad_size;
	logic        last_col;
	logic        last_row;
	logic [8:0]  col_inc;
	logic [8:0]  row_inc;

	assign in_ready = !valid_s1 || s2_ready;
	assign accept   = in_valid && in_ready;

	assign bad_size = (cfg.sprite_cols == 9'd0) || (cfg.sprite_rows == 9'd0) ||
		(cfg.sprite_cols > sbck_pkg::MAX_SPRITE_SIDE) ||
		(cfg.sprite_rows > sbck_pkg::MAX_SPRITE_SIDE);

	assign col_inc  = {1'b0, col_q} + 9'd1;
	assign row_inc  = {1'b0, row_q} + 9'd1;
	assign last_col = col_inc >= cfg.sprite_cols;
	assign last_row = row_inc >= cfg.sprite_rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= 8'd0;
			row_q    <= 8'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (bad_size || last_col) begin
					col_q <= 8'd0;
				end else begin
					col_q <= col_inc[7:0];
				end
				if (bad_size || (last_col && last_row)) begin
					row_q <= 8'd0;
				end else if (last_col) begin
					row_q <= row_inc[7:0];
				end
			end else if (s2_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scan_s1.color         <= src_color;
			scan_s1.col           <= col_q;
			scan_s1.row           <= row_q;
			scan_s1.rejected      <= bad_size;
			scan_s1.end_of_sprite <= !bad_size && last_col && last_row;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sbck_clip.sv -----
// ----------------------------------------------------------------------------
// Sprite blit clip and key stage
// Places the pixel on screen, clips it, applies the color key, holds result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbck_clip (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sbck_pkg::cfg_t cfg,
	input  wire logic          valid_s1,
	input  wire sbck_pkg::scan_t scan_s1,
	output logic               s2_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               write_enable,
	output logic [11:0]        target_x,
	output logic [11:0]        target_y,
	output logic [15:0]        out_color,
	output logic               end_of_sprite,
	output logic               rejected
);

	logic [12:0] scr_cols;
	logic [12:0] scr_rows;
	logic [16:0] dx;
	logic [16:0] dy;
	logic        on_screen;
	logic        keyed;
	logic        wr;

	assign scr_cols = (cfg.screen_cols > sbck_pkg::MAX_SCREEN_SIDE) ?
		sbck_pkg::MAX_SCREEN_SIDE : cfg.screen_cols;
	assign scr_rows = (cfg.screen_rows > sbck_pkg::MAX_SCREEN_SIDE) ?
		sbck_pkg::MAX_SCREEN_SIDE : cfg.screen_rows;

	assign dx = {cfg.origin_x[15], cfg.origin_x} + {9'd0, scan_s1.col};
	assign dy = {cfg.origin_y[15], cfg.origin_y} + {9'd0, scan_s1.row};

	assign on_screen = !dx[16] && (dx[15:0] < {3'd0, scr_cols}) &&
		!dy[16] && (dy[15:0] < {3'd0, scr_rows});
	assign keyed  = cfg.key_enable && (scan_s1.color == cfg.key_color);
	assign wr     = !scan_s1.rejected && on_screen && !keyed;

	assign s2_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			write_enable  <= wr;
			target_x      <= wr ? dx[11:0] : 12'd0;
			target_y      <= wr ? dy[11:0] : 12'd0;
			out_color     <= wr ? scan_s1.color : 16'd0;
			end_of_sprite <= scan_s1.end_of_sprite;
			rejected      <= scan_s1.rejected;
		end
	end

	`include "sprite_blit_clip_colorkey_core_assert.svh"

	`SBCK_ASSERT_SAME(a_write_in_screen, out_valid && write_enable, ({1'b0, target_x} < scr_cols) && ({1'b0, target_y} < scr_rows), "write target outside screen")
	`SBCK_ASSERT_SAME(a_reject_quiet, out_valid && rejected, !write_enable && !end_of_sprite, "rejected item carries a write or end mark")
	`SBCK_ASSERT_SAME(a_nowrite_zero, out_valid && !write_enable, (target_x == 12'd0) && (target_y == 12'd0) && (out_color == 16'd0), "idle write fields not cleared")
	`SBCK_ASSERT_NEXT(a_s1_held, valid_s1 && !s2_ready, valid_s1, "stage one item dropped while stalled")

endmodule

`default_nettype wire

// ----- hdl/sprite_blit_clip_colorkey_core.sv -----
// ----------------------------------------------------------------------------
// Sprite blit with clipping and color key
// Top level: config registers, scan stage and clip/key stage.
// ----------------------------------------------------------------------------
// Takes one RGB565 sprite pixel per item in row-major order and returns one
// result per item through the scan stage register and the output register.
// A new item is accepted every cycle while out_ready does not stall the output:
// the scan stage register and the output register each pass on while the stage
// after them is free, so the sustained rate is one item per clock unless
// out_ready stalls the output. Each result carries a screen write (clipped
// to the screen and skipped on the enabled key color), an end-of-sprite flag
// on the last pixel, and a reject flag when the sprite width or height is
// zero or above 256. Write the registers only while no item is in flight.
`default_nettype none

module sprite_blit_clip_colorkey_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] src_color,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             write_enable,
	output logic [11:0]      target_x,
	output logic [11:0]      target_y,
	output logic [15:0]      out_color,
	output logic             end_of_sprite,
	output logic             rejected
);

	sbck_pkg::cfg_t  cfg;
	sbck_pkg::scan_t scan_s1;
	logic            valid_s1;
	logic            s2_ready;

	sbck_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbck_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.src_color (src_color),
		.s2_ready  (s2_ready),
		.valid_s1  (valid_s1),
		.scan_s1   (scan_s1)
	);

	sbck_clip u_clip (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.scan_s1       (scan_s1),
		.s2_ready      (s2_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.target_x      (target_x),
		.target_y      (target_y),
		.out_color     (out_color),
		.end_of_sprite (end_of_sprite),
		.rejected      (rejected)
	);

endmodule

`default_nettype wire

// ----- dv/tb_sprite_blit_clip_colorkey_core.sv -----
// ----------------------------------------------------------------------------
// Sprite blit core testbench
// Streams RGB565 sprite pixels through the core under several register
// setups. Covers clipping at every screen edge, the color key, invalid sprite
// sizes and size changes in the middle of a sprite. Every result is checked
// field by field against a cycle-free model of the blit, with random stalls
// on both handshakes except in the last third of the random items.
// ----------------------------------------------------------------------------
module tb_sprite_blit_clip_colorkey_core;

	localparam int RANDOM_ITEMS = 550;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic        we;
		logic [11:0] tx;
		logic [11:0] ty;
		logic [15:0] color;
		logic        eos;
		logic        rejected;
	} blit_result_t;

	class pixel_write_ledger;
		blit_result_t       due_writes[$];
		int                 mismatches;
		logic signed [15:0] org_x;
		logic signed [15:0] org_y;
		logic [8:0]         spr_cols;
		logic [8:0]         spr_rows;
		logic [12:0]        scr_cols;
		logic [12:0]        scr_rows;
		logic               key_en;
		logic [15:0]        key_col;
		logic [7:0]         col_cnt;
		logic [7:0]         row_cnt;

		function new();
			mismatches = 0;
			org_x      = '0;
			org_y      = '0;
			spr_cols   = 9'd1;
			spr_rows   = 9'd1;
			scr_cols   = '0;
			scr_rows   = '0;
			key_en     = 1'b0;
			key_col    = '0;
			col_cnt    = '0;
			row_cnt    = '0;
		endfunction

		function void write_reg(sbck_pkg::reg_idx_t idx, logic [15:0] data);
			case (idx)
				sbck_pkg::REG_ORIGIN_X:    org_x    = data;
				sbck_pkg::REG_ORIGIN_Y:    org_y    = data;
				sbck_pkg::REG_SPRITE_COLS: spr_cols = data[8:0];
				sbck_pkg::REG_SPRITE_ROWS: spr_rows = data[8:0];
				sbck_pkg::REG_SCREEN_COLS: scr_cols = data[12:0];
				sbck_pkg::REG_SCREEN_ROWS: scr_rows = data[12:0];
				sbck_pkg::REG_KEY_ENABLE:  key_en   = data[0];
				sbck_pkg::REG_KEY_COLOR:   key_col  = data;
				default: ;
			endcase
		endfunction

		function int side_clip(logic [12:0] s);
			return (s > sbck_pkg::MAX_SCREEN_SIDE) ?
				int'(sbck_pkg::MAX_SCREEN_SIDE) : int'(s);
		endfunction

		function blit_result_t blit_pixel(logic [15:0] color);
			blit_result_t r;
			int           dx;
			int           dy;
			bit           on_screen;
			r = '0;
			if (spr_cols == 0 || spr_rows == 0 ||
			    spr_cols > sbck_pkg::MAX_SPRITE_SIDE ||
			    spr_rows > sbck_pkg::MAX_SPRITE_SIDE) begin
				col_cnt    = '0;
				row_cnt    = '0;
				r.rejected = 1'b1;
				return r;
			end
			dx = int'(org_x) + int'(col_cnt);
			dy = int'(org_y) + int'(row_cnt);
			on_screen = dx >= 0 && dx < side_clip(scr_cols) &&
			            dy >= 0 && dy < side_clip(scr_rows);
			if (on_screen && !(key_en && color == key_col)) begin
				r.we    = 1'b1;
				r.tx    = dx[11:0];
				r.ty    = dy[11:0];
				r.color = color;
			end
			if (int'(col_cnt) + 1 < int'(spr_cols)) begin
				col_cnt = col_cnt + 8'd1;
			end else if (int'(row_cnt) + 1 < int'(spr_rows)) begin
				col_cnt = '0;
				row_cnt = row_cnt + 8'd1;
			end else begin
				col_cnt = '0;
				row_cnt = '0;
				r.eos   = 1'b1;
			end
			return r;
		endfunction

		function void take_pixel(logic [15:0] color);
			due_writes.push_back(blit_pixel(color));
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_write(blit_result_t got);
			blit_result_t want;
			if (due_writes.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = due_writes.pop_front();
			check_field("write_enable", 16'(want.we), 16'(got.we));
			check_field("target_x", 16'(want.tx), 16'(got.tx));
			check_field("target_y", 16'(want.ty), 16'(got.ty));
			check_field("out_color", want.color, got.color);
			check_field("end_of_sprite", 16'(want.eos), 16'(got.eos));
			check_field("rejected", 16'(want.rejected), 16'(got.rejected));
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic [15:0] src_color = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        write_enable;
	logic [11:0] target_x;
	logic [11:0] target_y;
	logic [15:0] out_color;
	logic        end_of_sprite;
	logic        rejected;

	pixel_write_ledger ledger;
	int                send_idle = 26;
	int                recv_idle = 67;
	int                cycles    = 0;
	int                sent;
	int                n;
	int                prod;
	logic [15:0]       cur_key;
	logic [15:0]       c;
	logic [8:0]        cols;
	logic [8:0]        rows;
	logic [12:0]       sc;
	logic [12:0]       sr;

	sprite_blit_clip_colorkey_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.src_color     (src_color),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.target_x      (target_x),
		.target_y      (target_y),
		.out_color     (out_color),
		.end_of_sprite (end_of_sprite),
		.rejected      (rejected)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_write({write_enable, target_x, target_y, out_color,
			                    end_of_sprite, rejected});
	end

	task automatic send_pixel(logic [15:0] color);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		src_color <= color;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ledger.take_pixel(color);
	endtask

	// hold off until the pipeline is empty, then write
	task automatic set_reg(sbck_pkg::reg_idx_t idx, logic [15:0] data);
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.due_writes.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		ledger.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [8:0] pick_side();
		case ($urandom_range(0, 31))
			0:       return 9'd0;
			1:       return 9'($urandom_range(257, 511));
			2:       return 9'd256;
			default: return 9'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [12:0] pick_screen();
		case ($urandom_range(0, 7))
			0:       return 13'd0;
			1:       return 13'($urandom_range(4097, 8191));
			2:       return 13'd4096;
			default: return 13'($urandom_range(1, 24));
		endcase
	endfunction

	function automatic logic [15:0] pick_origin(logic [12:0] screen);
		int side;
		int v;
		side = (screen > sbck_pkg::MAX_SCREEN_SIDE) ?
			int'(sbck_pkg::MAX_SCREEN_SIDE) : int'(screen);
		case ($urandom_range(0, 9))
			0:       v = $urandom;
			1:       v = $urandom_range(0, 1) ? 32767 : -32768;
			2, 3:    v = side - int'($urandom_range(0, 6));
			default: v = int'($urandom_range(0, 8)) - 5;
		endcase
		return v[15:0];
	endfunction

	initial begin
		ledger = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset setup: 1x1 sprite on an empty screen
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);

		// oversized screen width, key enabled
		set_reg(sbck_pkg::REG_ORIGIN_X, 16'h0000);
		set_reg(sbck_pkg::REG_ORIGIN_Y, 16'h0000);
		set_reg(sbck_pkg::REG_SPRITE_COLS, 16'd3);
		set_reg(sbck_pkg::REG_SPRITE_ROWS, 16'd2);
		set_reg(sbck_pkg::REG_SCREEN_COLS, 16'd8191);
		set_reg(sbck_pkg::REG_SCREEN_ROWS, 16'd4096);
		set_reg(sbck_pkg::REG_KEY_ENABLE, 16'd1);
		set_reg(sbck_pkg::REG_KEY_COLOR, 16'hF800);
		send_pixel(16'hF800);
		send_pixel(16'hF801);
		send_pixel(16'h07E0);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'hF800);

		// far and near screen edges
		set_reg(sbck_pkg::REG_KEY_ENABLE, 16'd0);
		set_reg(sbck_pkg::REG_ORIGIN_X, 16'd4095);
		set_reg(sbck_pkg::REG_ORIGIN_Y, 16'hFFFF);
		set_reg(sbck_pkg::REG_SPRITE_COLS, 16'd2);
		send_pixel(16'hF800);
		send_pixel(16'h1234);
		send_pixel(16'hABCD);
		send_pixel(16'h5555);

		// shrink the sprite mid-way
		set_reg(sbck_pkg::REG_ORIGIN_X, 16'h0000);
		set_reg(sbck_pkg::REG_ORIGIN_Y, 16'h0000);
		set_reg(sbck_pkg::REG_SPRITE_COLS, 16'd4);
		set_reg(sbck_pkg::REG_SPRITE_ROWS, 16'd3);
		repeat (6) send_pixel(16'($urandom));
		set_reg(sbck_pkg::REG_SPRITE_COLS, 16'd2);
		repeat (3) send_pixel(16'($urandom));

		// extreme origins
		set_reg(sbck_pkg::REG_ORIGIN_X, 16'h7FFF);
		set_reg(sbck_pkg::REG_ORIGIN_Y, 16'h8000);
		send_pixel(16'hAAAA);

		// invalid sizes
		set_reg(sbck_pkg::REG_SPRITE_COLS, 16'd0);
		send_pixel(16'h0F0F);
		send_pixel(16'hF0F0);
		set_reg(sbck_pkg::REG_SPRITE_COLS, 16'd2);
		set_reg(sbck_pkg::REG_SPRITE_ROWS, 16'd257);
		send_pixel(16'h3C3C);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			cols    = pick_side();
			rows    = pick_side();
			sc      = pick_screen();
			sr      = pick_screen();
			cur_key = 16'($urandom);
			set_reg(sbck_pkg::REG_SCREEN_COLS, 16'(sc));
			set_reg(sbck_pkg::REG_SCREEN_ROWS, 16'(sr));
			set_reg(sbck_pkg::REG_ORIGIN_X, pick_origin(sc));
			set_reg(sbck_pkg::REG_ORIGIN_Y, pick_origin(sr));
			set_reg(sbck_pkg::REG_SPRITE_COLS, 16'(cols));
			set_reg(sbck_pkg::REG_SPRITE_ROWS, 16'(rows));
			set_reg(sbck_pkg::REG_KEY_ENABLE, 16'($urandom));
			set_reg(sbck_pkg::REG_KEY_COLOR, cur_key);
			prod = int'(cols) * int'(rows);
			if (prod == 0 || cols > sbck_pkg::MAX_SPRITE_SIDE ||
			    rows > sbck_pkg::MAX_SPRITE_SIDE)
				n = $urandom_range(1, 3);
			else if (prod > 64)
				n = (sent + prod <= RANDOM_ITEMS) ? prod : $urandom_range(8, 64);
			else
				n = prod * $urandom_range(1, 2) +
				    (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			repeat (n) begin
				if (sent < RANDOM_ITEMS / 3) begin
					send_idle = 26;
					recv_idle = 67;
				end else if (sent < 2 * RANDOM_ITEMS / 3) begin
					send_idle = 67;
					recv_idle = 26;
				end else begin
					send_idle = 0;
					recv_idle = 0;
				end
				case ($urandom_range(0, 9))
					0, 1, 2: c = cur_key;
					3:       c = cur_key ^ (16'd1 << $urandom_range(0, 15));
					default: c = 16'($urandom);
				endcase
				send_pixel(c);
				sent++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.due_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
